/* design/siof_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// siof_pkg: shared definitions
// Constants, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package siof_pkg;
  localparam int unsigned MaxRow = 8192;
  localparam int unsigned CntW   = $clog2(MaxRow + 1);
  localparam int unsigned PadW   = 14;

  localparam logic [2:0] RegRankCount  = 3'd0;
  localparam logic [2:0] RegOwnRank    = 3'd1;
  localparam logic [2:0] RegBlockSize  = 3'd2;
  localparam logic [2:0] RegBlockShift = 3'd3;
  localparam logic [2:0] RegStrideSh   = 3'd4;
  localparam logic [2:0] RegPow2Mode   = 3'd5;

  typedef struct packed {
    logic load;      // capture the input item
    logic div_start; // start the first division
    logic finish;    // finalize the item
  } siof_cmd_t;

  typedef struct packed {
    logic div_busy;  // division chain still running
    logic need_div;  // captured item requires division work
  } siof_sts_t;
endpackage
`default_nettype wire

/* design/siof_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// siof_div: restoring divider
// 32-bit unsigned divide, one quotient bit per cycle; zero divisor gives an
// all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
module siof_div import siof_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [31:0]      rem_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quot_q, quot_d, rem_q, rem_d, dsr_q, dsr_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q; quot_d = quot_q; rem_d = rem_q; dsr_d = dsr_q; done_d = 1'b0;
    trial = {rem_q, quot_q[31]};
    if (start_i) begin
      cnt_d = 6'd32; quot_d = dividend_i; rem_d = '0; dsr_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 32'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d; dsr_q <= dsr_d;
  end

  // The restoring scheme already yields all ones and the dividend for zero.
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

/* design/siof_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// siof_ctrl: controller
// Sequences capture, optional division and result hand-off.
// ----------------------------------------------------------------------------
module siof_ctrl import siof_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_busy_i,
  input  siof_sts_t sts_i,
  output siof_cmd_t cmd_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StEval;
        end
      end
      StEval: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StFin;
        end
      end
      StDiv: if (!sts_i.div_busy) state_d = StFin;
      StFin: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

/* design/siof_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// siof_dp: datapath
// Owner and local index computation, row counters and output register.
// ----------------------------------------------------------------------------
module siof_dp import siof_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [20:0] cfg_data_i,
  input  wire logic [31:0] global_index_i,
  input  wire logic        row_last_i,
  input  siof_cmd_t        cmd_i,
  output siof_sts_t        sts_o,
  output logic             out_busy_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             has_value_o,
  output logic [30:0]      local_index_o,
  output logic             row_done_o,
  output logic [13:0]      pad_count_o
);
  logic [8:0]  rank_count_q;
  logic [7:0]  own_rank_q;
  logic [20:0] block_size_q;
  logic [4:0]  block_shift_q, stride_shift_q;
  logic        pow2_q;

  logic [31:0] v_q;
  logic        last_q;
  logic [CntW-1:0] col_q, kept_q;
  logic [1:0]  dphase_q; // 0 idle, 1 v/bs, 2 blk/rc
  logic [31:0] rem_v_q, owner_q, bq_q;
  logic        ovalid_q, ovalid_d, ohas_q, odone_q;
  logic [30:0] olocal_q;
  logic [13:0] opad_q;

  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_quot, div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q <= 9'd1; own_rank_q <= '0; block_size_q <= 21'd1;
      block_shift_q <= '0; stride_shift_q <= '0; pow2_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRankCount:  rank_count_q <= cfg_data_i[8:0];
        RegOwnRank:    own_rank_q <= cfg_data_i[7:0];
        RegBlockSize:  block_size_q <= cfg_data_i;
        RegBlockShift: block_shift_q <= cfg_data_i[4:0];
        RegStrideSh:   stride_shift_q <= cfg_data_i[4:0];
        RegPow2Mode:   pow2_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic counted;
  assign counted = (col_q < CntW'(MaxRow));
  assign sts_o.need_div = counted && !v_q[31] && !pow2_q;
  assign sts_o.div_busy = (dphase_q != 2'd0);

  assign div_start = cmd_i.div_start || (dphase_q == 2'd1 && div_done);
  assign div_a = (dphase_q == 2'd1) ? div_quot : v_q;
  assign div_b = (dphase_q == 2'd1) ? {23'd0, rank_count_q} : {11'd0, block_size_q};

  siof_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dphase_q <= 2'd0;
    else if (cmd_i.div_start) dphase_q <= 2'd1;
    else if (div_done && dphase_q == 2'd1) dphase_q <= 2'd2;
    else if (div_done && dphase_q == 2'd2) dphase_q <= 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= global_index_i; last_q <= row_last_i;
    end
    if (div_done && dphase_q == 2'd1) rem_v_q <= div_rem;
    if (div_done && dphase_q == 2'd2) begin
      owner_q <= div_rem; bq_q <= div_quot;
    end
  end

  // Final owner/local selection; one multiply in division mode.
  logic [31:0] owner_c, local_c, bs_m1, rc_m1, prod;
  logic        kept_c;
  always_comb begin
    bs_m1 = {11'd0, block_size_q} - 32'd1;
    rc_m1 = {23'd0, rank_count_q} - 32'd1;
    prod = 32'(bq_q * {11'd0, block_size_q});
    if (pow2_q) begin
      owner_c = (v_q >> block_shift_q) & rc_m1;
      local_c = ((v_q >> stride_shift_q) << block_shift_q) | (v_q & bs_m1);
    end else begin
      owner_c = owner_q;
      local_c = prod + rem_v_q;
    end
    kept_c = counted && !v_q[31] && (owner_c == {24'd0, own_rank_q});
  end

  logic [CntW-1:0] col_n, kept_n;
  assign col_n  = counted ? col_q + CntW'(1) : col_q;
  assign kept_n = kept_c ? kept_q + CntW'(1) : kept_q;

  // A new result may be loaded in the same cycle the previous one transfers.
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    if (cmd_i.finish && (kept_c || last_q)) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; kept_q <= '0; ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (cmd_i.finish) begin
        col_q  <= last_q ? '0 : col_n;
        kept_q <= last_q ? '0 : kept_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      ohas_q <= kept_c;
      olocal_q <= kept_c ? local_c[30:0] : '0;
      odone_q <= last_q;
      opad_q <= last_q ? PadW'(col_n - kept_n) : '0;
    end
  end

  assign out_busy_o = ovalid_q && !out_ready_i;
  assign out_valid_o = ovalid_q;
  assign has_value_o = ohas_q;
  assign local_index_o = olocal_q;
  assign row_done_o = odone_q;
  assign pad_count_o = opad_q;
endmodule
`default_nettype wire

/* design/sparse_index_owner_filter_compact.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_index_owner_filter_compact: block-cyclic index filter
// Keeps indices owned by one rank, remaps them local, reports row padding.
// ----------------------------------------------------------------------------
// Channel | Direction | Fields
// in      | sink      | global_index, row_last
// out     | source    | has_value, local_index, row_done, pad_count
// cfg     | write     | cfg_we_i, cfg_index_i, cfg_data_i
// An item skips the divider in power-of-two mode, for negative indices and
// past MaxRow columns; otherwise it takes two passes of the bit-serial divider.
// Reset clears the counters and the output valid flag and sets the configuration to its defaults.
// A stalled output holds the controller in its finish step.
module sparse_index_owner_filter_compact import siof_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [20:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [31:0] global_index_i,
  input  wire logic        row_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             has_value_o,
  output logic [30:0]      local_index_o,
  output logic             row_done_o,
  output logic [13:0]      pad_count_o
);
  siof_cmd_t cmd;
  siof_sts_t sts;
  logic      out_busy;

  siof_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_busy_i(out_busy),
    .sts_i(sts), .cmd_o(cmd)
  );

  siof_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .global_index_i(global_index_i), .row_last_i, .cmd_i(cmd), .sts_o(sts),
    .out_busy_o(out_busy), .out_valid_o, .out_ready_i, .has_value_o,
    .local_index_o, .row_done_o, .pad_count_o
  );
endmodule
`default_nettype wire

/* design/siof_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// siof_checker: port-level checks
// Output handshake and result field consistency.
// ----------------------------------------------------------------------------
module siof_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        has_value_o,
  input wire logic [30:0] local_index_o,
  input wire logic        row_done_o,
  input wire logic [13:0] pad_count_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(local_index_o))
    else $error("output changed while stalled");
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_value_o || row_done_o)
    else $error("empty result");
  a_local0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_value_o |-> local_index_o == 31'd0)
    else $error("local index without value");
  a_pad0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_done_o |-> pad_count_o == 14'd0)
    else $error("pad count off row end");
endmodule

bind sparse_index_owner_filter_compact siof_checker u_chk (.*);
`default_nettype wire
